/* src/pas_bp_pkg.sv */
package pas_bp_pkg;

  // Default sizing of the predictor tables
  localparam int unsigned HistoryIndexBitsDef = 8;
  localparam int unsigned HistoryLengthDef    = 8;
  localparam int unsigned TableSelectBitsDef  = 8;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Table select shift after reset
  localparam logic [5:0] TableSelectShiftRst = 6'd56;

  // Saturating counter limits
  localparam logic [1:0] CtrMax = 2'd3;
  localparam logic [1:0] CtrMin = 2'b00;

  // Item modes
  localparam logic ModePredict = 1'b0;
  localparam logic ModeUpdate  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [63:0] branch_address;
    logic        is_direct;
    logic [63:0] branch_target;
    logic        was_taken;
  } item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIST,
    ST_PAT
  } back_state_e;

endpackage

/* src/pas_bp_ram.sv */
module pas_bp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/pas_bp_front.sv */
module pas_bp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                hold_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pas_bp_pkg::item_t   in_item_i,
  output logic                item_valid_o,
  input  logic                item_ready_i,
  output pas_bp_pkg::item_t   item_o
);
  import pas_bp_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  item_t           entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push, pop;

  // Take a beat while there is room and the back is not clearing its tables
  assign in_ready_o   = (cnt_q != (PtrW + 1)'(QueueDepth)) && !hold_i;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = entry_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = item_valid_o && item_ready_i;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

/* src/pas_bp_back.sv */
module pas_bp_back #(
  parameter int unsigned HISTORY_INDEX_BITS = pas_bp_pkg::HistoryIndexBitsDef,
  parameter int unsigned HISTORY_LENGTH     = pas_bp_pkg::HistoryLengthDef,
  parameter int unsigned TABLE_SELECT_BITS  = pas_bp_pkg::TableSelectBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [5:0]          table_select_shift_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  pas_bp_pkg::item_t   item_i,
  output logic                clearing_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                predict_taken_o,
  output logic [63:0]         predict_target_o
);
  import pas_bp_pkg::*;

  localparam int unsigned HistDepth = 2 ** HISTORY_INDEX_BITS;
  localparam int unsigned PatBits   = TABLE_SELECT_BITS + HISTORY_LENGTH;
  localparam int unsigned PatDepth  = 2 ** PatBits;
  localparam int unsigned ClrBits   = (HISTORY_INDEX_BITS > PatBits) ?
                                      HISTORY_INDEX_BITS : PatBits;

  back_state_e state_q, state_d;
  logic [ClrBits-1:0] clr_q, clr_d;
  item_t              item_q;
  logic [HISTORY_LENGTH-1:0] hist_q;
  logic [PatBits-1:0] pat_idx_q;
  logic [63:0]        last_target_q, last_target_d;
  logic               out_valid_q, out_valid_d;
  logic               out_taken_q;
  logic [63:0]        out_target_q;
  logic               out_load;
  logic               item_take;
  logic               hist_capture;

  // Table ports
  logic                          hist_we, hist_re;
  logic [HISTORY_INDEX_BITS-1:0] hist_waddr, hist_raddr;
  logic [HISTORY_LENGTH-1:0]     hist_wdata, hist_rdata;
  logic                          pat_we, pat_re;
  logic [PatBits-1:0]            pat_waddr, pat_raddr;
  logic [1:0]                    pat_wdata, pat_rdata;

  // Derived values
  logic [63:0]                  sel_shift;
  logic [63+HISTORY_LENGTH:0]   slot_full;
  logic [PatBits-1:0]           pat_idx;
  logic [HISTORY_LENGTH:0]      hist_shift;
  logic [1:0]                   ctr_next;
  logic                         out_free;

  pas_bp_ram #(
    .WIDTH (HISTORY_LENGTH),
    .DEPTH (HistDepth)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  pas_bp_ram #(
    .WIDTH (2),
    .DEPTH (PatDepth)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pat_waddr),
    .wdata_i (pat_wdata),
    .re_i    (pat_re),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  // Pattern slot: table select bits above the history, address bits past 63 read as zero
  assign sel_shift = item_q.branch_address >> table_select_shift_i;
  assign slot_full = {sel_shift, hist_rdata};
  assign pat_idx   = slot_full[PatBits-1:0];

  // Shift the outcome into the low end of the history
  assign hist_shift = {hist_q, item_q.was_taken};

  // Step the counter with saturation
  always_comb begin
    if (item_q.was_taken) begin
      ctr_next = (pat_rdata == CtrMax) ? CtrMax : pat_rdata + 2'd1;
    end else begin
      ctr_next = (pat_rdata == CtrMin) ? CtrMin : pat_rdata - 2'd1;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: clear sweep, history read, counter read, finish
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    last_target_d = last_target_q;
    item_take     = 1'b0;
    hist_capture  = 1'b0;
    out_load      = 1'b0;
    hist_we       = 1'b0;
    hist_waddr    = item_q.branch_address[HISTORY_INDEX_BITS-1:0];
    hist_wdata    = hist_shift[HISTORY_LENGTH-1:0];
    hist_re       = 1'b0;
    hist_raddr    = item_i.branch_address[HISTORY_INDEX_BITS-1:0];
    pat_we        = 1'b0;
    pat_waddr     = pat_idx_q;
    pat_wdata     = ctr_next;
    pat_re        = 1'b0;
    pat_raddr     = pat_idx;
    case (state_q)
      ST_CLEAR: begin
        hist_we    = ((clr_q >> HISTORY_INDEX_BITS) == '0);
        hist_waddr = clr_q[HISTORY_INDEX_BITS-1:0];
        hist_wdata = '0;
        pat_we     = 1'b1;
        pat_waddr  = clr_q[PatBits-1:0];
        pat_wdata  = CtrMin;
        clr_d      = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid_i) begin
          item_take = 1'b1;
          hist_re   = 1'b1;
          state_d   = ST_HIST;
        end
      end
      ST_HIST: begin
        hist_capture = 1'b1;
        pat_re       = 1'b1;
        state_d      = ST_PAT;
      end
      ST_PAT: begin
        if (item_q.mode == ModePredict) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          hist_we = 1'b1;
          pat_we  = 1'b1;
          if (item_q.was_taken && !item_q.is_direct) begin
            last_target_d = item_q.branch_target;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign item_ready_o = (state_q == ST_IDLE);
  assign clearing_o   = (state_q == ST_CLEAR);

  // Hold the result until the beat is taken
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      last_target_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      last_target_q <= last_target_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Capture item, history, slot and result payload
  always_ff @(posedge clk_i) begin
    if (item_take) begin
      item_q <= item_i;
    end
    if (hist_capture) begin
      hist_q    <= hist_rdata;
      pat_idx_q <= pat_idx;
    end
    if (out_load) begin
      out_taken_q  <= pat_rdata[1];
      out_target_q <= item_q.is_direct ? item_q.branch_target : last_target_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign predict_taken_o  = out_taken_q;
  assign predict_target_o = out_target_q;

endmodule

/* src/two_level_pas_branch_predictor_core.sv */
// Path: a predict beat shows its result after the queue hop, the history read and the
//   counter read into the result register; an update beat produces no result.
// One item at a time: the back takes the next after the last one's history and counter reads.
// Reset: a clearing pass over 2^max(HISTORY_INDEX_BITS, TABLE_SELECT_BITS + HISTORY_LENGTH)
//   addresses (65536 at defaults) zeroes both tables; no item is accepted meanwhile, writes
//   to table_select_shift are taken as always (reset value 56).
module two_level_pas_branch_predictor_core #(
  parameter int unsigned HISTORY_INDEX_BITS = pas_bp_pkg::HistoryIndexBitsDef,
  parameter int unsigned HISTORY_LENGTH     = pas_bp_pkg::HistoryLengthDef,
  parameter int unsigned TABLE_SELECT_BITS  = pas_bp_pkg::TableSelectBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [63:0] branch_address_i,
  input  logic        is_direct_i,
  input  logic [63:0] branch_target_i,
  input  logic        was_taken_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        predict_taken_o,
  output logic [63:0] predict_target_o
);
  import pas_bp_pkg::*;

  logic [5:0] table_select_shift_q;
  item_t      in_item;
  item_t      queue_item;
  logic       queue_valid, queue_ready;
  logic       clearing;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_select_shift_q <= TableSelectShiftRst;
    end else if (cfg_we_i) begin
      table_select_shift_q <= cfg_wdata_i;
    end
  end

  assign in_item.mode           = mode_i;
  assign in_item.branch_address = branch_address_i;
  assign in_item.is_direct      = is_direct_i;
  assign in_item.branch_target  = branch_target_i;
  assign in_item.was_taken      = was_taken_i;

  pas_bp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hold_i       (clearing),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .item_valid_o (queue_valid),
    .item_ready_i (queue_ready),
    .item_o       (queue_item)
  );

  pas_bp_back #(
    .HISTORY_INDEX_BITS (HISTORY_INDEX_BITS),
    .HISTORY_LENGTH     (HISTORY_LENGTH),
    .TABLE_SELECT_BITS  (TABLE_SELECT_BITS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .table_select_shift_i (table_select_shift_q),
    .item_valid_i         (queue_valid),
    .item_ready_o         (queue_ready),
    .item_i               (queue_item),
    .clearing_o           (clearing),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .predict_taken_o      (predict_taken_o),
    .predict_target_o     (predict_target_o)
  );

endmodule
